@@ hdl/pfld_pkg.sv @@
// Shared types and constants for the page framebuffer line draw block.
// Used by the top level, the port checker, the result checker and the testbench.
// Depends on nothing.
package pfld_pkg;

    localparam int PANEL_WIDTH = 128;
    localparam int STORE_BYTES = 1024;

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int CUR_W  = ADDR_W + 1;
    localparam int CNT_W  = $clog2(STORE_BYTES + 1);

    localparam int ROWS_SMALL   = 32;
    localparam int ROWS_LARGE   = 64;
    localparam int HEIGHT_SPLIT = 64;

    localparam int VIS_SMALL_RAW = (ROWS_SMALL / 8) * PANEL_WIDTH;
    localparam int VIS_LARGE_RAW = (ROWS_LARGE / 8) * PANEL_WIDTH;
    localparam int VIS_SMALL = (VIS_SMALL_RAW < STORE_BYTES) ? VIS_SMALL_RAW : STORE_BYTES;
    localparam int VIS_LARGE = (VIS_LARGE_RAW < STORE_BYTES) ? VIS_LARGE_RAW : STORE_BYTES;

    localparam int PADDR_W = 3;
    localparam logic REG_IDX_PANEL_HEIGHT = 1'b0;
    localparam logic [6:0] PANEL_HEIGHT_RESET = 7'd64;

    localparam logic [7:0] WIN_EMPTY_LOW  = 8'hFF;
    localparam logic [7:0] WIN_EMPTY_HIGH = 8'h00;

    typedef enum logic [2:0] {
        CMD_PIXEL = 3'd0,
        CMD_HLINE = 3'd1,
        CMD_VLINE = 3'd2,
        CMD_CLEAR = 3'd3,
        CMD_READ  = 3'd4,
        CMD_TAKE  = 3'd5,
        CMD_LOAD  = 3'd6,
        CMD_NOP   = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        COL_CLEAR  = 2'd0,
        COL_SET    = 2'd1,
        COL_INVERT = 2'd2,
        COL_KEEP   = 2'd3
    } colour_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SETUP,
        S_RUN,
        S_DRAIN,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_RMW_H,
        OP_RMW_V,
        OP_FILL,
        OP_READ
    } op_t;

endpackage

@@ hdl/pfld_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the frame store; no package dependency.
module pfld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/page_framebuffer_line_draw_top.sv @@
// Top level of the page framebuffer line draw block: command sequencer,
// dirty window, APB register and the frame store. Depends on pfld_pkg and pfld_ram.
//
//   Channel   | Direction | Handshake            | Payload
//   ----------+-----------+----------------------+------------------------------------------
//   command   | in        | in_valid / in_ready  | command, pos_x, pos_y, run_length, colour,
//             |           |                      | byte_index, byte_value
//   result    | out       | out_valid / out_ready| read_value, win_left, win_right, win_top,
//             |           |                      | win_bottom, win_nonempty
//   config    | in        | APB psel / penable   | panel_height at byte address 0
//
// One command is processed at a time. Its result goes valid in the same cycle in which
// in_ready rises again. A command passes a set-up state, a run step for each of the N
// store bytes it touches, a drain state and a done state; with N zero it goes from
// set-up to done. N is 1 for a pixel, load or read, the clipped length for a horizontal
// run, the page count for a vertical run, the visible byte count (512 or 1024) for
// clear, and 0 for take window, no-op, colour three, an off-panel start, a zero length
// or a load past the visible pages. The frame store takes one read-modify-write per
// cycle. After reset the store is swept to zero, one byte a cycle, before the first
// command is accepted. A stalled result does not block the next transfer; the command
// after it waits in its final cycle until the stalled result is taken.
module page_framebuffer_line_draw_top (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pfld_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  command,
    input  logic [7:0]                  pos_x,
    input  logic [7:0]                  pos_y,
    input  logic [7:0]                  run_length,
    input  logic [1:0]                  colour,
    input  logic [9:0]                  byte_index,
    input  logic [7:0]                  byte_value,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  read_value,
    output logic [7:0]                  win_left,
    output logic [7:0]                  win_right,
    output logic [7:0]                  win_top,
    output logic [7:0]                  win_bottom,
    output logic                        win_nonempty
);

    localparam int ADDR_W = pfld_pkg::ADDR_W;
    localparam int CUR_W  = pfld_pkg::CUR_W;
    localparam int CNT_W  = pfld_pkg::CNT_W;

    // Control state.
    pfld_pkg::state_t  state_reg, state_next;
    pfld_pkg::op_t     op_reg, op_next;
    logic              out_valid_reg, out_valid_next;
    logic              p1_valid_reg, p1_valid_next;
    logic [6:0]        panel_height_reg, panel_height_next;
    logic [7:0]        dirty_left_reg, dirty_left_next;
    logic [7:0]        dirty_right_reg, dirty_right_next;
    logic [7:0]        dirty_top_reg, dirty_top_next;
    logic [7:0]        dirty_bottom_reg, dirty_bottom_next;
    logic [CUR_W-1:0]  cur_addr_reg, cur_addr_next;
    logic [CNT_W-1:0]  remaining_reg, remaining_next;
    logic              first_reg, first_next;
    logic [7:0]        fill_data_reg, fill_data_next;

    // Latched command and working payload.
    pfld_pkg::cmd_t    cmd_reg, cmd_next;
    pfld_pkg::colour_t colour_reg, colour_next;
    logic [7:0]        x_reg, x_next;
    logic [7:0]        y_reg, y_next;
    logic [7:0]        len_reg, len_next;
    logic [9:0]        bidx_reg, bidx_next;
    logic [7:0]        bval_reg, bval_next;
    logic [7:0]        mask_reg, mask_next;
    logic [2:0]        y_lo_reg, y_lo_next;
    logic [2:0]        last_lo_reg, last_lo_next;
    logic [ADDR_W-1:0] p1_addr_reg, p1_addr_next;
    logic [7:0]        p1_mask_reg, p1_mask_next;
    logic              rd_flag_reg, rd_flag_next;
    logic [7:0]        res_read_reg, res_read_next;
    logic [7:0]        res_left_reg, res_left_next;
    logic [7:0]        res_right_reg, res_right_next;
    logic [7:0]        res_top_reg, res_top_next;
    logic [7:0]        res_bottom_reg, res_bottom_next;
    logic [7:0]        out_read_reg, out_read_next;
    logic [7:0]        out_left_reg, out_left_next;
    logic [7:0]        out_right_reg, out_right_next;
    logic [7:0]        out_top_reg, out_top_next;
    logic [7:0]        out_bottom_reg, out_bottom_next;
    logic              out_nonempty_reg, out_nonempty_next;

    // Frame store ports.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    // Setup decode.
    logic [7:0]        rows;
    logic              on_panel;
    logic [8:0]        h_sum;
    logic [8:0]        v_sum;
    logic [7:0]        h_end;
    logic [7:0]        v_last;
    logic [CUR_W-1:0]  base_addr;
    logic [CNT_W-1:0]  vis_bytes;
    logic [2:0]        v_lo;
    logic [2:0]        v_hi;
    logic [7:0]        v_mask;
    logic              in_store;
    logic              cfg_write;

    pfld_ram #(
        .WIDTH (8),
        .DEPTH (pfld_pkg::STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The APB register is always ready; only word 0 exists.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == pfld_pkg::REG_IDX_PANEL_HEIGHT);
    assign prdata    = (paddr[2] == pfld_pkg::REG_IDX_PANEL_HEIGHT) ?
                       32'(panel_height_reg) : 32'd0;

    // Panel geometry from the height register.
    assign rows      = (panel_height_reg < 7'(pfld_pkg::HEIGHT_SPLIT)) ?
                       8'(pfld_pkg::ROWS_SMALL) : 8'(pfld_pkg::ROWS_LARGE);
    assign vis_bytes = (panel_height_reg < 7'(pfld_pkg::HEIGHT_SPLIT)) ?
                       CNT_W'(pfld_pkg::VIS_SMALL) : CNT_W'(pfld_pkg::VIS_LARGE);
    assign on_panel  = (x_reg < 8'(pfld_pkg::PANEL_WIDTH)) && (y_reg < rows);

    // Run ends after clipping at the right or bottom edge.
    assign h_sum  = {1'b0, x_reg} + {1'b0, len_reg};
    assign v_sum  = {1'b0, y_reg} + {1'b0, len_reg};
    assign h_end  = (h_sum > 9'(pfld_pkg::PANEL_WIDTH)) ?
                    8'(pfld_pkg::PANEL_WIDTH - 1) : 8'(h_sum - 9'd1);
    assign v_last = (v_sum > {1'b0, rows}) ? (rows - 8'd1) : 8'(v_sum - 9'd1);

    assign base_addr = CUR_W'(y_reg[7:3]) * CUR_W'(pfld_pkg::PANEL_WIDTH) + CUR_W'(x_reg);

    // Vertical run masks: partial top and bottom pages, whole bytes between.
    assign v_lo   = first_reg ? y_lo_reg : 3'd0;
    assign v_hi   = (remaining_reg == CNT_W'(1)) ? last_lo_reg : 3'd7;
    assign v_mask = (8'hFF << v_lo) & (8'hFF >> (3'd7 - v_hi));

    assign in_store = cur_addr_reg < CUR_W'(pfld_pkg::STORE_BYTES);

    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        out_valid_next    = out_valid_reg;
        p1_valid_next     = 1'b0;
        panel_height_next = panel_height_reg;
        dirty_left_next   = dirty_left_reg;
        dirty_right_next  = dirty_right_reg;
        dirty_top_next    = dirty_top_reg;
        dirty_bottom_next = dirty_bottom_reg;
        cur_addr_next     = cur_addr_reg;
        remaining_next    = remaining_reg;
        first_next        = first_reg;
        fill_data_next    = fill_data_reg;

        cmd_next          = cmd_reg;
        colour_next       = colour_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        len_next          = len_reg;
        bidx_next         = bidx_reg;
        bval_next         = bval_reg;
        mask_next         = mask_reg;
        y_lo_next         = y_lo_reg;
        last_lo_next      = last_lo_reg;
        p1_addr_next      = p1_addr_reg;
        p1_mask_next      = p1_mask_reg;
        rd_flag_next      = rd_flag_reg;
        res_read_next     = res_read_reg;
        res_left_next     = res_left_reg;
        res_right_next    = res_right_reg;
        res_top_next      = res_top_reg;
        res_bottom_next   = res_bottom_reg;
        out_read_next     = out_read_reg;
        out_left_next     = out_left_reg;
        out_right_next    = out_right_reg;
        out_top_next      = out_top_reg;
        out_bottom_next   = out_bottom_reg;
        out_nonempty_next = out_nonempty_reg;

        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = cur_addr_reg[ADDR_W-1:0];
        ram_wdata = fill_data_reg;
        ram_raddr = cur_addr_reg[ADDR_W-1:0];

        if (cfg_write)
        begin
            panel_height_next = pwdata[6:0];
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Second stage of a read-modify-write: the byte read last cycle is back.
        if (p1_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = p1_addr_reg;
            unique case (colour_reg)
                pfld_pkg::COL_CLEAR:  ram_wdata = ram_rdata & ~p1_mask_reg;
                pfld_pkg::COL_SET:    ram_wdata = ram_rdata | p1_mask_reg;
                pfld_pkg::COL_INVERT: ram_wdata = ram_rdata ^ p1_mask_reg;
                default:              ram_wdata = ram_rdata;
            endcase
        end

        unique case (state_reg)
            pfld_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next    = pfld_pkg::cmd_t'(command);
                    colour_next = pfld_pkg::colour_t'(colour);
                    x_next      = pos_x;
                    y_next      = pos_y;
                    len_next    = run_length;
                    bidx_next   = byte_index;
                    bval_next   = byte_value;
                    state_next  = pfld_pkg::S_SETUP;
                end
            end

            pfld_pkg::S_SETUP:
            begin
                op_next        = pfld_pkg::OP_NONE;
                remaining_next = '0;
                first_next     = 1'b1;
                res_read_next  = 8'd0;
                mask_next      = 8'(1 << y_reg[2:0]);
                y_lo_next      = y_reg[2:0];
                last_lo_next   = v_last[2:0];
                cur_addr_next  = base_addr;

                // Window after the command; take window reports the old one.
                res_left_next   = dirty_left_reg;
                res_right_next  = dirty_right_reg;
                res_top_next    = dirty_top_reg;
                res_bottom_next = dirty_bottom_reg;

                priority case (1'b1)
                    (cmd_reg == pfld_pkg::CMD_PIXEL) && on_panel:
                    begin
                        op_next        = pfld_pkg::OP_RMW_H;
                        remaining_next = CNT_W'(1);
                        res_left_next   = (dirty_left_reg > x_reg) ? x_reg : dirty_left_reg;
                        res_right_next  = (dirty_right_reg < x_reg) ? x_reg : dirty_right_reg;
                        res_top_next    = (dirty_top_reg > y_reg) ? y_reg : dirty_top_reg;
                        res_bottom_next = (dirty_bottom_reg < y_reg) ? y_reg : dirty_bottom_reg;
                    end
                    (cmd_reg == pfld_pkg::CMD_HLINE) && on_panel && (len_reg != 8'd0):
                    begin
                        op_next        = pfld_pkg::OP_RMW_H;
                        remaining_next = CNT_W'(h_end - x_reg) + CNT_W'(1);
                        res_left_next   = (dirty_left_reg > x_reg) ? x_reg : dirty_left_reg;
                        res_right_next  = (dirty_right_reg < h_end) ? h_end : dirty_right_reg;
                        res_top_next    = (dirty_top_reg > y_reg) ? y_reg : dirty_top_reg;
                        res_bottom_next = (dirty_bottom_reg < y_reg) ? y_reg : dirty_bottom_reg;
                    end
                    (cmd_reg == pfld_pkg::CMD_VLINE) && on_panel && (len_reg != 8'd0):
                    begin
                        op_next        = pfld_pkg::OP_RMW_V;
                        remaining_next = CNT_W'(v_last[7:3] - y_reg[7:3]) + CNT_W'(1);
                        res_left_next   = (dirty_left_reg > x_reg) ? x_reg : dirty_left_reg;
                        res_right_next  = (dirty_right_reg < x_reg) ? x_reg : dirty_right_reg;
                        res_top_next    = (dirty_top_reg > y_reg) ? y_reg : dirty_top_reg;
                        res_bottom_next = (dirty_bottom_reg < v_last) ? v_last : dirty_bottom_reg;
                    end
                    (cmd_reg == pfld_pkg::CMD_CLEAR):
                    begin
                        op_next        = pfld_pkg::OP_FILL;
                        fill_data_next = 8'd0;
                        cur_addr_next  = '0;
                        remaining_next = vis_bytes;
                        res_left_next   = 8'd0;
                        res_right_next  = 8'(pfld_pkg::PANEL_WIDTH - 1);
                        res_top_next    = 8'd0;
                        res_bottom_next = rows - 8'd1;
                    end
                    (cmd_reg == pfld_pkg::CMD_LOAD):
                    begin
                        op_next        = pfld_pkg::OP_FILL;
                        fill_data_next = bval_reg;
                        cur_addr_next  = CUR_W'(bidx_reg);
                        remaining_next = (CNT_W'(bidx_reg) < vis_bytes) ? CNT_W'(1) : '0;
                        res_left_next   = 8'd0;
                        res_right_next  = 8'(pfld_pkg::PANEL_WIDTH - 1);
                        res_top_next    = 8'd0;
                        res_bottom_next = rows - 8'd1;
                    end
                    (cmd_reg == pfld_pkg::CMD_READ):
                    begin
                        op_next        = pfld_pkg::OP_READ;
                        cur_addr_next  = CUR_W'(bidx_reg);
                        remaining_next = CNT_W'(1);
                    end
                    default:
                    begin
                        op_next = pfld_pkg::OP_NONE;
                    end
                endcase

                // Colour three widens the window but leaves every pixel alone.
                if ((cmd_reg == pfld_pkg::CMD_PIXEL || cmd_reg == pfld_pkg::CMD_HLINE ||
                     cmd_reg == pfld_pkg::CMD_VLINE) && (colour_reg == pfld_pkg::COL_KEEP))
                begin
                    remaining_next = '0;
                end

                if (cmd_reg == pfld_pkg::CMD_TAKE)
                begin
                    dirty_left_next   = pfld_pkg::WIN_EMPTY_LOW;
                    dirty_right_next  = pfld_pkg::WIN_EMPTY_HIGH;
                    dirty_top_next    = pfld_pkg::WIN_EMPTY_LOW;
                    dirty_bottom_next = pfld_pkg::WIN_EMPTY_HIGH;
                end
                else
                begin
                    dirty_left_next   = res_left_next;
                    dirty_right_next  = res_right_next;
                    dirty_top_next    = res_top_next;
                    dirty_bottom_next = res_bottom_next;
                end

                state_next = (remaining_next == '0) ? pfld_pkg::S_DONE : pfld_pkg::S_RUN;
            end

            pfld_pkg::S_INIT, pfld_pkg::S_RUN:
            begin
                unique case (op_reg)
                    pfld_pkg::OP_RMW_H:
                    begin
                        p1_valid_next = in_store;
                        p1_addr_next  = cur_addr_reg[ADDR_W-1:0];
                        p1_mask_next  = mask_reg;
                        cur_addr_next = cur_addr_reg + CUR_W'(1);
                    end
                    pfld_pkg::OP_RMW_V:
                    begin
                        p1_valid_next = in_store;
                        p1_addr_next  = cur_addr_reg[ADDR_W-1:0];
                        p1_mask_next  = v_mask;
                        cur_addr_next = cur_addr_reg + CUR_W'(pfld_pkg::PANEL_WIDTH);
                    end
                    pfld_pkg::OP_FILL:
                    begin
                        ram_we        = in_store;
                        ram_waddr     = cur_addr_reg[ADDR_W-1:0];
                        ram_wdata     = fill_data_reg;
                        cur_addr_next = cur_addr_reg + CUR_W'(1);
                    end
                    pfld_pkg::OP_READ:
                    begin
                        rd_flag_next = in_store;
                    end
                    default:
                    begin
                    end
                endcase

                first_next     = 1'b0;
                remaining_next = remaining_reg - CNT_W'(1);
                if (remaining_reg == CNT_W'(1))
                begin
                    state_next = (state_reg == pfld_pkg::S_INIT) ?
                                 pfld_pkg::S_IDLE : pfld_pkg::S_DRAIN;
                end
            end

            pfld_pkg::S_DRAIN:
            begin
                // The last write-back of a run lands in this cycle.
                if (op_reg == pfld_pkg::OP_READ)
                begin
                    res_read_next = rd_flag_reg ? ram_rdata : 8'd0;
                end
                state_next = pfld_pkg::S_DONE;
            end

            pfld_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    out_read_next     = res_read_reg;
                    out_left_next     = res_left_reg;
                    out_right_next    = res_right_reg;
                    out_top_next      = res_top_reg;
                    out_bottom_next   = res_bottom_reg;
                    out_nonempty_next = (res_top_reg <= res_bottom_reg) &&
                                        (res_left_reg <= res_right_reg);
                    state_next        = pfld_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = pfld_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pfld_pkg::S_INIT;
            op_reg           <= pfld_pkg::OP_FILL;
            out_valid_reg    <= 1'b0;
            p1_valid_reg     <= 1'b0;
            panel_height_reg <= pfld_pkg::PANEL_HEIGHT_RESET;
            dirty_left_reg   <= pfld_pkg::WIN_EMPTY_LOW;
            dirty_right_reg  <= pfld_pkg::WIN_EMPTY_HIGH;
            dirty_top_reg    <= pfld_pkg::WIN_EMPTY_LOW;
            dirty_bottom_reg <= pfld_pkg::WIN_EMPTY_HIGH;
            cur_addr_reg     <= '0;
            remaining_reg    <= CNT_W'(pfld_pkg::STORE_BYTES);
            first_reg        <= 1'b0;
            fill_data_reg    <= 8'd0;
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            out_valid_reg    <= out_valid_next;
            p1_valid_reg     <= p1_valid_next;
            panel_height_reg <= panel_height_next;
            dirty_left_reg   <= dirty_left_next;
            dirty_right_reg  <= dirty_right_next;
            dirty_top_reg    <= dirty_top_next;
            dirty_bottom_reg <= dirty_bottom_next;
            cur_addr_reg     <= cur_addr_next;
            remaining_reg    <= remaining_next;
            first_reg        <= first_next;
            fill_data_reg    <= fill_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        colour_reg       <= colour_next;
        x_reg            <= x_next;
        y_reg            <= y_next;
        len_reg          <= len_next;
        bidx_reg         <= bidx_next;
        bval_reg         <= bval_next;
        mask_reg         <= mask_next;
        y_lo_reg         <= y_lo_next;
        last_lo_reg      <= last_lo_next;
        p1_addr_reg      <= p1_addr_next;
        p1_mask_reg      <= p1_mask_next;
        rd_flag_reg      <= rd_flag_next;
        res_read_reg     <= res_read_next;
        res_left_reg     <= res_left_next;
        res_right_reg    <= res_right_next;
        res_top_reg      <= res_top_next;
        res_bottom_reg   <= res_bottom_next;
        out_read_reg     <= out_read_next;
        out_left_reg     <= out_left_next;
        out_right_reg    <= out_right_next;
        out_top_reg      <= out_top_next;
        out_bottom_reg   <= out_bottom_next;
        out_nonempty_reg <= out_nonempty_next;
    end

    assign out_valid    = out_valid_reg;
    assign read_value   = out_read_reg;
    assign win_left     = out_left_reg;
    assign win_right    = out_right_reg;
    assign win_top      = out_top_reg;
    assign win_bottom   = out_bottom_reg;
    assign win_nonempty = out_nonempty_reg;

endmodule

@@ hdl/pfld_checker.sv @@
// Port-level checker for the page framebuffer line draw top level, and its bind.
// Depends on pfld_pkg for the panel geometry.
module pfld_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] read_value,
    input logic [7:0] win_left,
    input logic [7:0] win_right,
    input logic [7:0] win_top,
    input logic [7:0] win_bottom,
    input logic       win_nonempty
);

    // A stalled result keeps its read value and its left window edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(win_left))
        else $error("result changed while stalled");

    // Commands are processed one at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second command taken while one is in flight");

    // The nonempty flag agrees with the reported window.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> win_nonempty == ((win_top <= win_bottom) && (win_left <= win_right)))
        else $error("window flag inconsistent");

    // The window never reaches past the panel on its high edges.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (win_right <= 8'(pfld_pkg::PANEL_WIDTH - 1)) &&
                      (win_bottom <= 8'(pfld_pkg::ROWS_LARGE - 1)))
        else $error("window beyond panel");

endmodule

bind page_framebuffer_line_draw_top pfld_checker u_pfld_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_value   (read_value),
    .win_left     (win_left),
    .win_right    (win_right),
    .win_top      (win_top),
    .win_bottom   (win_bottom),
    .win_nonempty (win_nonempty)
);

@@ sim/pfld_window_checker.sv @@
// Result checker for the page framebuffer line draw block: mirrors the frame store,
// the dirty window and the panel height register, and compares every result transfer.
// Depends on pfld_pkg.
`timescale 1ns / 1ps

module pfld_window_checker (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pfld_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    input  logic [31:0]                  prdata,
    input  logic                         pready,

    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [2:0]                   command,
    input  logic [7:0]                   pos_x,
    input  logic [7:0]                   pos_y,
    input  logic [7:0]                   run_length,
    input  logic [1:0]                   colour,
    input  logic [9:0]                   byte_index,
    input  logic [7:0]                   byte_value,

    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [7:0]                   read_value,
    input  logic [7:0]                   win_left,
    input  logic [7:0]                   win_right,
    input  logic [7:0]                   win_top,
    input  logic [7:0]                   win_bottom,
    input  logic                         win_nonempty,

    output int                           fail_count,
    output int                           replies_waiting
);

    import pfld_pkg::*;

    localparam logic [PADDR_W-1:0] HEIGHT_ADDR = PADDR_W'(4 * REG_IDX_PANEL_HEIGHT);

    typedef struct packed {
        logic [7:0] read_value;
        logic [7:0] w_left;
        logic [7:0] w_right;
        logic [7:0] w_top;
        logic [7:0] w_bottom;
        logic       w_nonempty;
    } window_reply_t;

    logic [7:0]    frame_mem [0:STORE_BYTES-1];
    logic [7:0]    win_l;
    logic [7:0]    win_r;
    logic [7:0]    win_t;
    logic [7:0]    win_b;
    logic [6:0]    height_reg;
    window_reply_t replies_due [$];
    int            reply_number;

    task automatic flag_mismatch(input string what, input int exp_val, input int got_val);
        $display("[%0t] result %0d: %s expected %0d, got %0d",
                 $time, reply_number, what, exp_val, got_val);
        fail_count++;
    endtask

    task automatic paint(input int addr, input logic [7:0] bits, input colour_t col);
        if (addr < STORE_BYTES)
        begin
            case (col)
                COL_CLEAR:  frame_mem[addr] = frame_mem[addr] & ~bits;
                COL_SET:    frame_mem[addr] = frame_mem[addr] | bits;
                COL_INVERT: frame_mem[addr] = frame_mem[addr] ^ bits;
                default:    ;
            endcase
        end
    endtask

    task automatic widen(input int l, input int r, input int t, input int b);
        if (int'(win_l) > l) win_l = 8'(l);
        if (int'(win_r) < r) win_r = 8'(r);
        if (int'(win_t) > t) win_t = 8'(t);
        if (int'(win_b) < b) win_b = 8'(b);
    endtask

    // Applies one command to the mirrored state and returns the result it must produce.
    task automatic run_command(input cmd_t op, input logic [7:0] x, input logic [7:0] y,
                               input logic [7:0] len, input colour_t col,
                               input logic [9:0] idx, input logic [7:0] val,
                               output window_reply_t rep);
        int         rows;
        int         vis;
        int         n;
        int         end_row;
        int         lo;
        int         hi;
        int         i;
        logic [7:0] bits;
        bit         on_panel;
        rows = (height_reg < HEIGHT_SPLIT) ? ROWS_SMALL : ROWS_LARGE;
        vis = (rows == ROWS_SMALL) ? VIS_SMALL : VIS_LARGE;
        on_panel = (int'(x) < PANEL_WIDTH) && (int'(y) < rows);
        n = len;
        rep = '0;
        case (op)
            CMD_PIXEL:
                if (on_panel)
                begin
                    paint(int'(y) / 8 * PANEL_WIDTH + int'(x), 8'd1 << y[2:0], col);
                    widen(x, x, y, y);
                end
            CMD_HLINE:
                if (on_panel && n != 0)
                begin
                    if (int'(x) + n > PANEL_WIDTH) n = PANEL_WIDTH - int'(x);
                    for (i = 0; i < n; i++)
                        paint(int'(y) / 8 * PANEL_WIDTH + int'(x) + i, 8'd1 << y[2:0], col);
                    widen(x, int'(x) + n - 1, y, y);
                end
            CMD_VLINE:
                if (on_panel && n != 0)
                begin
                    if (int'(y) + n > rows) n = rows - int'(y);
                    end_row = int'(y) + n - 1;
                    for (i = int'(y) / 8; i <= end_row / 8; i++)
                    begin
                        lo = (i == int'(y) / 8) ? int'(y) % 8 : 0;
                        hi = (i == end_row / 8) ? end_row % 8 : 7;
                        bits = (8'hFF << lo) & (8'hFF >> (7 - hi));
                        paint(i * PANEL_WIDTH + int'(x), bits, col);
                    end
                    widen(x, x, y, end_row);
                end
            CMD_CLEAR:
            begin
                for (i = 0; i < vis; i++)
                    frame_mem[i] = 8'h00;
                win_l = 8'd0;
                win_r = 8'(PANEL_WIDTH - 1);
                win_t = 8'd0;
                win_b = 8'(rows - 1);
            end
            CMD_READ:
                if (int'(idx) < STORE_BYTES)
                    rep.read_value = frame_mem[idx];
            CMD_LOAD:
            begin
                if (int'(idx) < vis)
                    frame_mem[idx] = val;
                win_l = 8'd0;
                win_r = 8'(PANEL_WIDTH - 1);
                win_t = 8'd0;
                win_b = 8'(rows - 1);
            end
            default: ;
        endcase
        rep.w_left = win_l;
        rep.w_right = win_r;
        rep.w_top = win_t;
        rep.w_bottom = win_b;
        rep.w_nonempty = (win_t <= win_b) && (win_l <= win_r);
        // Taking the window reports it as it was, then empties it.
        if (op == CMD_TAKE)
        begin
            win_l = WIN_EMPTY_LOW;
            win_r = WIN_EMPTY_HIGH;
            win_t = WIN_EMPTY_LOW;
            win_b = WIN_EMPTY_HIGH;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        window_reply_t fresh;
        window_reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_BYTES; i++)
                frame_mem[i] = 8'h00;
            win_l = WIN_EMPTY_LOW;
            win_r = WIN_EMPTY_HIGH;
            win_t = WIN_EMPTY_LOW;
            win_b = WIN_EMPTY_HIGH;
            height_reg = PANEL_HEIGHT_RESET;
            replies_due.delete();
            reply_number = 0;
            fail_count = 0;
            replies_waiting = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == HEIGHT_ADDR)
            begin
                if (pwrite)
                    height_reg = pwdata[6:0];
                else if (prdata !== {25'd0, height_reg})
                    flag_mismatch("panel_height readback", height_reg, prdata);
            end
            // The oldest result is retired before a command taken at the same edge is added.
            if (out_valid && out_ready)
            begin
                if (replies_due.size() == 0)
                begin
                    flag_mismatch("commands outstanding", 1, 0);
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (read_value !== want.read_value)
                        flag_mismatch("read_value", want.read_value, read_value);
                    if (win_left !== want.w_left)
                        flag_mismatch("win_left", want.w_left, win_left);
                    if (win_right !== want.w_right)
                        flag_mismatch("win_right", want.w_right, win_right);
                    if (win_top !== want.w_top)
                        flag_mismatch("win_top", want.w_top, win_top);
                    if (win_bottom !== want.w_bottom)
                        flag_mismatch("win_bottom", want.w_bottom, win_bottom);
                    if (win_nonempty !== want.w_nonempty)
                        flag_mismatch("win_nonempty", want.w_nonempty, win_nonempty);
                end
                reply_number++;
            end
            if (in_valid && in_ready)
            begin
                run_command(cmd_t'(command), pos_x, pos_y, run_length, colour_t'(colour),
                            byte_index, byte_value, fresh);
                replies_due.push_back(fresh);
            end
            replies_waiting = replies_due.size();
        end
    end

endmodule

@@ sim/testbench.sv @@
// Top of the testbench for page_framebuffer_line_draw_top: clock, reset, APB set-up,
// command stimulus, result back-pressure and the final verdict.
// Depends on pfld_pkg, the block's RTL and pfld_window_checker.
`timescale 1ns / 1ps

module testbench;

    import pfld_pkg::*;

    localparam logic [PADDR_W-1:0] HEIGHT_ADDR = PADDR_W'(4 * REG_IDX_PANEL_HEIGHT);
    // Random commands per panel height setting.
    localparam int PHASE_ITEMS = 330;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    logic [2:0]          command;
    logic [7:0]          pos_x;
    logic [7:0]          pos_y;
    logic [7:0]          run_length;
    logic [1:0]          colour;
    logic [9:0]          byte_index;
    logic [7:0]          byte_value;
    logic                out_valid;
    logic                out_ready;
    logic [7:0]          read_value;
    logic [7:0]          win_left;
    logic [7:0]          win_right;
    logic [7:0]          win_top;
    logic [7:0]          win_bottom;
    logic                win_nonempty;
    int                  fail_count;
    int                  replies_waiting;
    bit                  sender_rush;

    page_framebuffer_line_draw_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .run_length   (run_length),
        .colour       (colour),
        .byte_index   (byte_index),
        .byte_value   (byte_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_value   (read_value),
        .win_left     (win_left),
        .win_right    (win_right),
        .win_top      (win_top),
        .win_bottom   (win_bottom),
        .win_nonempty (win_nonempty)
    );

    // The checker sees exactly what the block sees and keeps the expected results.
    pfld_window_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .run_length      (run_length),
        .colour          (colour),
        .byte_index      (byte_index),
        .byte_value      (byte_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .read_value      (read_value),
        .win_left        (win_left),
        .win_right       (win_right),
        .win_top         (win_top),
        .win_bottom      (win_bottom),
        .win_nonempty    (win_nonempty),
        .fail_count      (fail_count),
        .replies_waiting (replies_waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guard against a hang. The slowest legal run (every command a full clear with the
    // longest stalls on both sides, plus the power-up sweep) needs under 20 ms.
    initial
    begin
        #80_000_000;
        $display("Verification failed");
        $finish;
    end

    // All tasks below start and end at a falling edge, which is where inputs change.

    // One command transfer. The sender either idles for a random number of cycles or,
    // during a rush, keeps valid high straight into the next command.
    task automatic send_item(input cmd_t op, input logic [7:0] x, input logic [7:0] y,
                             input logic [7:0] len, input colour_t col,
                             input logic [9:0] idx, input logic [7:0] val);
        int gap;
        if ($urandom_range(0, 39) == 0)
            sender_rush = !sender_rush;
        gap = sender_rush ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        command <= op;
        pos_x <= x;
        pos_y <= y;
        run_length <= len;
        colour <= col;
        byte_index <= idx;
        byte_value <= val;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly well-formed draws on the panel, with some off-panel starts, zero lengths,
    // runs that overshoot the edge and load indexes past the visible pages mixed in.
    task automatic send_random_item(input int rows);
        int         pick;
        int         vis;
        cmd_t       op;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] len;
        logic [9:0] idx;
        vis = (rows == ROWS_SMALL) ? VIS_SMALL : VIS_LARGE;
        pick = $urandom_range(0, 99);
        if (pick < 20)      op = CMD_PIXEL;
        else if (pick < 45) op = CMD_HLINE;
        else if (pick < 65) op = CMD_VLINE;
        else if (pick < 67) op = CMD_CLEAR;
        else if (pick < 78) op = CMD_READ;
        else if (pick < 84) op = CMD_TAKE;
        else if (pick < 96) op = CMD_LOAD;
        else                op = CMD_NOP;
        x = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, PANEL_WIDTH - 1))
                                          : 8'($urandom_range(0, 255));
        y = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, rows - 1))
                                          : 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            len = 8'd0;
        else if (pick < 4)
            len = 8'($urandom_range(0, 255));
        else
            len = 8'($urandom_range(1, 16));
        if (op == CMD_LOAD && $urandom_range(0, 99) < 80)
            idx = 10'($urandom_range(0, vis - 1));
        else
            idx = 10'($urandom_range(0, STORE_BYTES - 1));
        send_item(op, x, y, len, colour_t'($urandom_range(0, 3)), idx,
                  8'($urandom_range(0, 255)));
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [6:0] value);
        logic [31:0] word;
        // Upper bits carry noise; the register keeps only its seven low bits.
        word = $urandom;
        word[6:0] = value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // The checker compares prdata at the access edge.
    task automatic apb_read(input logic [PADDR_W-1:0] addr);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        while (replies_waiting != 0)
            @(negedge clk);
    endtask

    // Result side: out_ready drops for a random number of cycles before each transfer,
    // with occasional rushes where it stays high.
    initial
    begin : result_sink
        int hold;
        bit rush;
        rush = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rush = !rush;
            hold = rush ? 0 : $urandom_range(0, 10);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        logic [6:0] heights [0:4];
        int         rows;
        heights[0] = 7'd32;
        heights[1] = 7'd64;
        heights[2] = 7'd63;
        heights[3] = 7'd40;
        heights[4] = 7'd64;
        sender_rush = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        command = CMD_NOP;
        pos_x = '0;
        pos_y = '0;
        run_length = '0;
        colour = COL_CLEAR;
        byte_index = '0;
        byte_value = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed commands at the reset height of 64 rows. The first transfer is only
        // taken once the block has finished sweeping the store after reset.
        send_item(CMD_READ,    8'd0,   8'd0,   8'd0,   COL_CLEAR,  10'd0,    8'd0);
        send_item(CMD_TAKE,    8'd0,   8'd0,   8'd0,   COL_CLEAR,  10'd0,    8'd0);
        // Pixels at both corners, then starts just past the right and bottom edges.
        send_item(CMD_PIXEL,   8'd0,   8'd0,   8'd0,   COL_SET,    10'd0,    8'd0);
        send_item(CMD_PIXEL,   8'd127, 8'd63,  8'd0,   COL_SET,    10'd0,    8'd0);
        send_item(CMD_PIXEL,   8'd128, 8'd0,   8'd0,   COL_SET,    10'd0,    8'd0);
        send_item(CMD_PIXEL,   8'd0,   8'd64,  8'd0,   COL_SET,    10'd0,    8'd0);
        // Horizontal runs: a full-width clipped run, a zero length, a clip at the edge.
        send_item(CMD_HLINE,   8'd0,   8'd5,   8'd255, COL_SET,    10'd0,    8'd0);
        send_item(CMD_HLINE,   8'd100, 8'd9,   8'd0,   COL_INVERT, 10'd0,    8'd0);
        send_item(CMD_HLINE,   8'd120, 8'd63,  8'd20,  COL_INVERT, 10'd0,    8'd0);
        // Vertical runs: clipped at the bottom, inside one page, across pages, off panel.
        send_item(CMD_VLINE,   8'd3,   8'd2,   8'd255, COL_SET,    10'd0,    8'd0);
        send_item(CMD_VLINE,   8'd7,   8'd10,  8'd3,   COL_INVERT, 10'd0,    8'd0);
        send_item(CMD_VLINE,   8'd9,   8'd5,   8'd20,  COL_CLEAR,  10'd0,    8'd0);
        send_item(CMD_VLINE,   8'd255, 8'd255, 8'd255, COL_INVERT, 10'd0,    8'd0);
        // The no-change colour leaves pixels alone but still grows the window.
        send_item(CMD_PIXEL,   8'd50,  8'd20,  8'd0,   COL_KEEP,   10'd0,    8'd0);
        send_item(CMD_HLINE,   8'd60,  8'd40,  8'd10,  COL_KEEP,   10'd0,    8'd0);
        // Store access at the last address and at address zero.
        send_item(CMD_READ,    8'd0,   8'd0,   8'd0,   COL_CLEAR,  10'd1023, 8'd0);
        send_item(CMD_LOAD,    8'd0,   8'd0,   8'd0,   COL_CLEAR,  10'd1023, 8'hFF);
        send_item(CMD_READ,    8'd0,   8'd0,   8'd0,   COL_CLEAR,  10'd1023, 8'd0);
        send_item(CMD_LOAD,    8'd0,   8'd0,   8'd0,   COL_CLEAR,  10'd0,    8'hA5);
        // Taking the window twice shows the full window and then the empty one.
        send_item(CMD_TAKE,    8'd0,   8'd0,   8'd0,   COL_CLEAR,  10'd0,    8'd0);
        send_item(CMD_TAKE,    8'd0,   8'd0,   8'd0,   COL_CLEAR,  10'd0,    8'd0);
        send_item(CMD_CLEAR,   8'd0,   8'd0,   8'd0,   COL_CLEAR,  10'd0,    8'd0);
        send_item(CMD_READ,    8'd0,   8'd0,   8'd0,   COL_CLEAR,  10'd1023, 8'd0);
        // The unused command with every field at its top value.
        send_item(CMD_NOP,     8'd255, 8'd255, 8'd255, COL_KEEP,   10'd1023, 8'hFF);
        send_item(CMD_VLINE,   8'd127, 8'd0,   8'd64,  COL_INVERT, 10'd0,    8'd0);
        in_valid <= 1'b0;
        wait_drained();
        apb_read(HEIGHT_ADDR);

        // Random phases, each under its own panel height. The register is only touched
        // once every result of the previous phase has come back.
        for (int phase = 0; phase < 5; phase++)
        begin
            wait_drained();
            apb_write(HEIGHT_ADDR, heights[phase]);
            apb_read(HEIGHT_ADDR);
            rows = (heights[phase] < HEIGHT_SPLIT) ? ROWS_SMALL : ROWS_LARGE;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random_item(rows);
            in_valid <= 1'b0;
        end

        // Drain, then allow one longest command's worth of cycles for stray results.
        wait_drained();
        repeat (STORE_BYTES + 64) @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
